FILE: hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types for the fixed-point ALU
// Operation codes and the control group that travels down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  // Operation codes carried in the cmd field
  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_MIN      = 4'd4,
    CMD_MAX      = 4'd5,
    CMD_INC      = 4'd6,
    CMD_DEC      = 4'd7,
    CMD_TO_INT   = 4'd8,
    CMD_FROM_INT = 4'd9
  } cmd_e;

  // Per-beat control bits that ride along with the datapath
  typedef struct packed {
    logic is_div;  // beat is a divide, result comes from the quotient
    logic q_neg;   // operand signs differ, negate the quotient magnitude
    logic dz;      // divide with a zero divisor
    logic less;    // operand_a < operand_b, signed
    logic equal;   // operand_a == operand_b
  } ctl_t;

  localparam int unsigned DataW = 32;

endpackage : fpa_pkg

`default_nettype wire

FILE: hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: decode, compare, multiply and divider setup
// Two register stages: the first holds the simple results, the raw product
// and the divider magnitudes; the second scales the product toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned QW        = 32 + FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [3:0]         cmd_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output fpa_pkg::ctl_t           ctl_o,
  output logic [31:0]             res_o,
  output logic [QW-1:0]           nq_o,
  output logic [31:0]             dvs_o
);

  localparam logic signed [63:0] RndAdd = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  // stage one registers
  logic                 v1_q;
  logic                 is_mul1_q, is_mul1_d;
  logic signed [63:0]   prod1_q, prod1_d;
  logic [31:0]          simple1_q, simple1_d;
  fpa_pkg::ctl_t        ctl1_q, ctl1_d;
  logic [QW-1:0]        nq1_q, nq1_d;
  logic [31:0]          dvs1_q, dvs1_d;

  // stage two registers
  logic                 v2_q;
  logic [31:0]          res2_q, res2_d;
  fpa_pkg::ctl_t        ctl2_q;
  logic [QW-1:0]        nq2_q;
  logic [31:0]          dvs2_q;

  logic                 en1, en2;
  logic [31:0]          abs_a, abs_b;
  logic signed [63:0]   mul_adj;
  fpa_pkg::cmd_e        cmd;

  // a stage moves when it is empty or the next one moves
  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  assign cmd   = fpa_pkg::cmd_e'(cmd_i);
  assign abs_a = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign abs_b = b_i[31] ? (~b_i + 32'd1) : b_i;

  // stage one: compares, simple ops, product, divider magnitudes
  always_comb begin
    ctl1_d.less   = (a_i < b_i);
    ctl1_d.equal  = (a_i == b_i);
    ctl1_d.is_div = (cmd == fpa_pkg::CMD_DIV);
    ctl1_d.q_neg  = a_i[31] ^ b_i[31];
    ctl1_d.dz     = (cmd == fpa_pkg::CMD_DIV) && (b_i == 32'sd0);
    is_mul1_d     = (cmd == fpa_pkg::CMD_MUL);
    prod1_d       = 64'(a_i) * 64'(b_i);
    nq1_d         = {abs_a, {FRAC_BITS{1'b0}}};
    dvs1_d        = abs_b;
    case (cmd)
      fpa_pkg::CMD_ADD:      simple1_d = a_i + b_i;
      fpa_pkg::CMD_SUB:      simple1_d = a_i - b_i;
      fpa_pkg::CMD_MIN:      simple1_d = (a_i > b_i) ? b_i : a_i;
      fpa_pkg::CMD_MAX:      simple1_d = (a_i < b_i) ? b_i : a_i;
      fpa_pkg::CMD_INC:      simple1_d = a_i + 32'sd1;
      fpa_pkg::CMD_DEC:      simple1_d = a_i - 32'sd1;
      fpa_pkg::CMD_TO_INT:   simple1_d = a_i >>> FRAC_BITS;
      fpa_pkg::CMD_FROM_INT: simple1_d = a_i << FRAC_BITS;
      default:               simple1_d = 32'd0;
    endcase
  end

  // stage two: product divided by 2^FRAC_BITS, truncated toward zero
  assign mul_adj = prod1_q + (prod1_q[63] ? RndAdd : 64'sd0);
  always_comb begin
    res2_d = simple1_q;
    if (is_mul1_q) begin
      res2_d = 32'(mul_adj >>> FRAC_BITS);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en1) begin
      is_mul1_q <= is_mul1_d;
      prod1_q   <= prod1_d;
      simple1_q <= simple1_d;
      ctl1_q    <= ctl1_d;
      nq1_q     <= nq1_d;
      dvs1_q    <= dvs1_d;
    end
    if (en2) begin
      res2_q <= res2_d;
      ctl2_q <= ctl1_q;
      nq2_q  <= nq1_q;
      dvs2_q <= dvs1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign ctl_o       = ctl2_q;
  assign res_o       = res2_q;
  assign nq_o        = nq2_q;
  assign dvs_o       = dvs2_q;

endmodule : fpa_front

`default_nettype wire

FILE: hdl/fpa_div_step.sv
// ----------------------------------------------------------------------------
// fpa_div_step: one restoring-division stage
// Shifts one dividend bit into the partial remainder and retires one
// quotient bit into the low end of the shared dividend/quotient word.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_step #(
  parameter int unsigned QW = 40
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire fpa_pkg::ctl_t ctl_i,
  input  wire logic [31:0]   res_i,
  input  wire logic [31:0]   rem_i,
  input  wire logic [QW-1:0] nq_i,
  input  wire logic [31:0]   dvs_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output fpa_pkg::ctl_t      ctl_o,
  output logic [31:0]        res_o,
  output logic [31:0]        rem_o,
  output logic [QW-1:0]      nq_o,
  output logic [31:0]        dvs_o
);

  logic            v_q;
  logic            en;
  fpa_pkg::ctl_t   ctl_q;
  logic [31:0]     res_q;
  logic [31:0]     rem_q, rem_d;
  logic [QW-1:0]   nq_q, nq_d;
  logic [31:0]     dvs_q;
  logic [32:0]     rem_sh;
  logic [32:0]     rem_sub;
  logic            ge;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  // trial subtract of the divisor from the shifted remainder
  assign rem_sh  = {rem_i, nq_i[QW-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_i});
  assign rem_sub = rem_sh - {1'b0, dvs_i};
  assign rem_d   = ge ? rem_sub[31:0] : rem_sh[31:0];
  assign nq_d    = {nq_i[QW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q <= ctl_i;
      res_q <= res_i;
      rem_q <= rem_d;
      nq_q  <= nq_d;
      dvs_q <= dvs_i;
    end
  end

  assign out_valid_o = v_q;
  assign ctl_o       = ctl_q;
  assign res_o       = res_q;
  assign rem_o       = rem_q;
  assign nq_o        = nq_q;
  assign dvs_o       = dvs_q;

endmodule : fpa_div_step

`default_nettype wire

FILE: hdl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: result select and output register
// Applies the quotient sign, forces zero on a zero divisor and holds the
// finished beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire fpa_pkg::ctl_t ctl_i,
  input  wire logic [31:0]   res_i,
  input  wire logic [31:0]   quo_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [31:0]        result_o,
  output logic               a_less_o,
  output logic               a_equal_o,
  output logic               div_by_zero_o
);

  logic        v_q;
  logic        en;
  logic [31:0] result_q, result_d;
  logic        less_q, equal_q, dz_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  // pick the quotient for divides, signed and zeroed as needed
  always_comb begin
    result_d = res_i;
    if (ctl_i.is_div) begin
      if (ctl_i.dz) begin
        result_d = 32'd0;
      end else if (ctl_i.q_neg) begin
        result_d = ~quo_i + 32'd1;
      end else begin
        result_d = quo_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q <= result_d;
      less_q   <= ctl_i.less;
      equal_q  <= ctl_i.equal;
      dz_q     <= ctl_i.dz;
    end
  end

  assign out_valid_o   = v_q;
  assign result_o      = result_q;
  assign a_less_o      = less_q;
  assign a_equal_o     = equal_q;
  assign div_by_zero_o = dz_q;

  // a zero divisor always yields a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && dz_q) |-> (result_q == 32'd0))
    else $error("fpa_back: divide by zero with nonzero result");

  // less and equal are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> !(less_q && equal_q))
    else $error("fpa_back: less and equal both set");

  // a held beat keeps its contents while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && !out_ready_i) |=> (v_q && $stable(result_q) && $stable(dz_q)))
    else $error("fpa_back: stalled result changed");

endmodule : fpa_back

`default_nettype wire

FILE: hdl/fixed_point_alu_top.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_top: pipelined signed fixed-point ALU
// Slave stream beat: tdata = {operand_b, operand_a, cmd}, one result beat
// per input beat on the master stream: {div_by_zero, a_equal, a_less, result}.
//
// Usage:
//   - One beat enters whenever s_axis_tvalid_i and s_axis_tready_o are high.
//   - A beat passes two front stages, 32 + FRAC_BITS divider stages and one
//     output stage on its way to the result beat; the divider, one quotient
//     bit per stage, sets that depth.
//   - Throughput is one beat per cycle while m_axis_tready_i stays high;
//     every operation takes the same path, so results leave in input order.
//   - Each stage advances when it is empty or the stage after it advances,
//     so bubbles are squeezed out and new beats are taken while a finished
//     result waits in the output register.
//   - When the receiver holds m_axis_tready_i low, the pipeline fills up and
//     s_axis_tready_o drops; nothing is lost or repeated.
//   - Reset clears all valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_top #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [3:0] cmd, [35:4] operand_a, [67:36] operand_b, [71:68] zero
  input  wire logic [71:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [31:0] result, [32] a_less, [33] a_equal, [34] div_by_zero, [39:35] zero
  output logic [39:0]      m_axis_tdata_o
);

  localparam int unsigned QW = fpa_pkg::DataW + FRAC_BITS;

  logic                 vld_w [0:QW];
  logic                 rdy_w [0:QW];
  fpa_pkg::ctl_t        ctl_w [0:QW];
  logic [31:0]          res_w [0:QW];
  logic [31:0]          rem_w [0:QW];
  logic [QW-1:0]        nq_w  [0:QW];
  logic [31:0]          dvs_w [0:QW];

  logic [31:0]          result;
  logic                 a_less, a_equal, div_by_zero;

  // front stages: decode, multiply, divider setup
  fpa_front #(
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_i       (s_axis_tdata_i[3:0]),
    .a_i         (s_axis_tdata_i[35:4]),
    .b_i         (s_axis_tdata_i[67:36]),
    .out_valid_o (vld_w[0]),
    .out_ready_i (rdy_w[0]),
    .ctl_o       (ctl_w[0]),
    .res_o       (res_w[0]),
    .nq_o        (nq_w[0]),
    .dvs_o       (dvs_w[0])
  );

  assign rem_w[0] = 32'd0;

  // divider: one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    fpa_div_step #(
      .QW (QW)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld_w[k]),
      .in_ready_o  (rdy_w[k]),
      .ctl_i       (ctl_w[k]),
      .res_i       (res_w[k]),
      .rem_i       (rem_w[k]),
      .nq_i        (nq_w[k]),
      .dvs_i       (dvs_w[k]),
      .out_valid_o (vld_w[k+1]),
      .out_ready_i (rdy_w[k+1]),
      .ctl_o       (ctl_w[k+1]),
      .res_o       (res_w[k+1]),
      .rem_o       (rem_w[k+1]),
      .nq_o        (nq_w[k+1]),
      .dvs_o       (dvs_w[k+1])
    );
  end

  // output stage
  fpa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (vld_w[QW]),
    .in_ready_o    (rdy_w[QW]),
    .ctl_i         (ctl_w[QW]),
    .res_i         (res_w[QW]),
    .quo_i         (nq_w[QW][31:0]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .result_o      (result),
    .a_less_o      (a_less),
    .a_equal_o     (a_equal),
    .div_by_zero_o (div_by_zero)
  );

  assign m_axis_tdata_o = {5'd0, div_by_zero, a_equal, a_less, result};

endmodule : fixed_point_alu_top

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stream-level test of the fixed-point ALU
// Directed beats cover wrap-around, multiply and divide truncation, a zero
// divisor, min/max ties, integer-part rounding and the unused codes; random
// beats follow under changing sender/receiver pacing. Every result beat is
// checked field by field against an in-order queue of predicted results.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned FracBits      = 8;
  localparam int unsigned PipeLatency   = FracBits + 35;
  localparam int unsigned WatchdogLimit = 4000;
  // codes with no operation behind them
  localparam logic [3:0]  CMD_SPARE_LO  = 4'd10;
  localparam logic [3:0]  CMD_SPARE_HI  = 4'd15;

  // one result beat, [34:0] of m_axis_tdata
  typedef struct packed {
    logic        div_by_zero;
    logic        a_equal;
    logic        a_less;
    logic [31:0] result;
  } alu_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [71:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;

  alu_res_t    expected_q[$];
  alu_res_t    want;
  alu_res_t    got;
  int unsigned err_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned src_idle_pct = 23;
  int unsigned sink_idle_pct = 74;

  fixed_point_alu_top #(
    .FRAC_BITS (FracBits)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted result for one beat
  function automatic alu_res_t alu_predict(input logic [3:0] cmd,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_res_t r;
    longint   scale;
    longint   wide;
    r = '0;
    scale = longint'(1) << FracBits;
    r.a_less = (a < b);
    r.a_equal = (a == b);
    case (cmd)
      fpa_pkg::CMD_ADD:      r.result = a + b;
      fpa_pkg::CMD_SUB:      r.result = a - b;
      fpa_pkg::CMD_MUL: begin
        // exact product, truncated toward zero, then wrapped
        wide = (longint'(a) * longint'(b)) / scale;
        r.result = wide[31:0];
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          wide = (longint'(a) * scale) / longint'(b);
          r.result = wide[31:0];
        end
      end
      fpa_pkg::CMD_MIN:      r.result = (a > b) ? b : a;
      fpa_pkg::CMD_MAX:      r.result = (a < b) ? b : a;
      fpa_pkg::CMD_INC:      r.result = a + 32'sd1;
      fpa_pkg::CMD_DEC:      r.result = a - 32'sd1;
      fpa_pkg::CMD_TO_INT:   r.result = a >>> FracBits;
      fpa_pkg::CMD_FROM_INT: r.result = a << FracBits;
      default:               r.result = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns MISMATCH: %s", $realtime, what);
    err_count++;
  endtask

  // Send one beat with random idle cycles ahead of it
  task automatic send_op(input logic [3:0] cmd, input logic [31:0] a,
                         input logic [31:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {4'b0, b, a, cmd};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    expected_q.push_back(alu_predict(cmd, a, b));
  endtask

  // Receiver pacing
  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (m_valid && m_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", m_data));
      end else begin
        want = expected_q.pop_front();
        got  = m_data[34:0];
        if (got.result !== want.result)
          report_mismatch($sformatf("result %h, want %h", got.result, want.result));
        if (got.a_less !== want.a_less)
          report_mismatch($sformatf("a_less %b, want %b", got.a_less, want.a_less));
        if (got.a_equal !== want.a_equal)
          report_mismatch($sformatf("a_equal %b, want %b", got.a_equal, want.a_equal));
        if (got.div_by_zero !== want.div_by_zero)
          report_mismatch($sformatf("div_by_zero %b, want %b",
                                    got.div_by_zero, want.div_by_zero));
      end
    end
  end

  // Watchdog: too long without any beat moving
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Operand mix: full range, small values, fixed-point values, corners
  function automatic logic [31:0] pick_corner();
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(7))
      0, 1, 2: v = $urandom;
      3, 4:    v = 32'($urandom_range(4095)) - 32'd2048;
      5:       v = pick_corner();
      6:       v = pick_corner() + 32'($urandom_range(2)) - 32'd1;
      default: v = ((32'($urandom_range(511)) - 32'd256) << FracBits)
                   | 32'($urandom_range((1 << FracBits) - 1));
    endcase
    return v;
  endfunction

  function automatic logic [3:0] pick_cmd();
    if ($urandom_range(9) == 0)
      return 4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    return 4'($urandom_range(fpa_pkg::CMD_FROM_INT, fpa_pkg::CMD_ADD));
  endfunction

  // Wrap-around on add, sub, inc, dec and integer-to-fixed
  task automatic test_wrap_edges();
    send_op(fpa_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    send_op(fpa_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000);
    send_op(fpa_pkg::CMD_SUB, 32'h8000_0000, 32'h0000_0001);
    send_op(fpa_pkg::CMD_SUB, 32'h0000_0000, 32'h8000_0000);
    send_op(fpa_pkg::CMD_INC, 32'h7FFF_FFFF, 32'h0000_0000);
    send_op(fpa_pkg::CMD_DEC, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(fpa_pkg::CMD_FROM_INT, 32'h0100_0000, 32'h1234_5678);
    send_op(fpa_pkg::CMD_FROM_INT, 32'hFFFF_FFFF, 32'h8000_0000);
  endtask

  // Truncation toward zero and wrap on multiply and divide
  task automatic test_mul_div();
    send_op(fpa_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    send_op(fpa_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
    send_op(fpa_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(fpa_pkg::CMD_DIV, 32'h0000_0001, 32'h7FFF_FFFF);
    send_op(fpa_pkg::CMD_DIV, 32'hFFFF_FFFD, 32'h0000_0002);
  endtask

  // Zero divisor gives zero and the flag
  task automatic test_div_by_zero();
    send_op(fpa_pkg::CMD_DIV, 32'h0000_0005, 32'h0000_0000);
    send_op(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'h0000_0000);
  endtask

  // Ties and the full-range pair on min/max
  task automatic test_min_max();
    send_op(fpa_pkg::CMD_MIN, 32'h0000_0007, 32'h0000_0007);
    send_op(fpa_pkg::CMD_MAX, 32'h0000_0007, 32'h0000_0007);
    send_op(fpa_pkg::CMD_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(fpa_pkg::CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  // Integer part rounds toward minus infinity
  task automatic test_to_int();
    send_op(fpa_pkg::CMD_TO_INT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(fpa_pkg::CMD_TO_INT, 32'hFFFF_FEFF, 32'h0000_0000);
    send_op(fpa_pkg::CMD_TO_INT, 32'h7FFF_FFFF, 32'h0000_0000);
  endtask

  // Unused codes: zero result, compare flags still valid
  task automatic test_unused_codes();
    send_op(CMD_SPARE_LO, 32'h1234_5678, 32'h1234_5678);
    send_op(CMD_SPARE_HI, 32'hFFFF_FFF0, 32'h0000_0010);
  endtask

  // Random beats; equal pairs and zero divisors are forced now and then
  task automatic test_random_stream(input int unsigned count);
    logic [3:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      cmd = pick_cmd();
      a   = pick_operand();
      case ($urandom_range(9))
        0:       b = a;
        1:       b = '0;
        default: b = pick_operand();
      endcase
      send_op(cmd, a, b);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_wrap_edges();
    test_mul_div();
    test_div_by_zero();
    test_min_max();
    test_to_int();
    test_unused_codes();

    test_random_stream(384);
    src_idle_pct  = 74;
    sink_idle_pct = 23;
    test_random_stream(383);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_stream(383);
    s_valid <= 1'b0;

    // drain, then give the pipeline time to show any extra beat
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PipeLatency + 5) @(posedge clk);

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
